>>> hdl/virtual_periodic_tick_timer_unit_assert.svh
// Assertion macros shared by the tick timer modules.
`ifndef VIRTUAL_PERIODIC_TICK_TIMER_UNIT_ASSERT_SVH
`define VIRTUAL_PERIODIC_TICK_TIMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, off while reset is held.
`define VPTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tick timer check failed");
// Next-cycle implication, off while reset is held.
`define VPTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tick timer check failed");
`else
`define VPTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VPTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/vptt_pkg.sv
// Shared codes and control/status types of the tick timer.
package vptt_pkg;

  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ALARM   = 2'd3;

  localparam logic [15:0] TPU_RESET = 16'd1000;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture input item, clear result
    logic mul;         // period = period_us * ticks_per_usec
    logic start;       // set deadline and alarm, enable
    logic disable_tmr; // cancel alarm, disable
    logic alarm;       // mark alarm pending
    logic poll_start;  // clear pending, clear count
    logic scan_step;   // count one deadline, advance by one period
    logic diff;        // remaining = deadline - vtime
    logic rearm;       // alarm = tsc_now + remaining
    logic publish;     // move result into output register
  } vptt_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             enabled;
    logic             pending;
    logic             scan_more;
  } vptt_sts_t;

endpackage

>>> hdl/vptt_ctrl.sv
// Sequencing state machine of the tick timer.
`include "virtual_periodic_tick_timer_unit_assert.svh"
module vptt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  vptt_pkg::vptt_sts_t sts,
  output vptt_pkg::vptt_ctl_t ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_DIFF   = 3'd5;
  localparam logic [2:0] S_REARM  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Decode state into datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          vptt_pkg::CMD_ENABLE: begin
            state_nxt = S_MUL;
          end
          vptt_pkg::CMD_DISABLE: begin
            ctl.disable_tmr = sts.enabled;
            state_nxt       = S_DONE;
          end
          vptt_pkg::CMD_POLL: begin
            if (sts.pending) begin
              ctl.poll_start = 1'b1;
              state_nxt      = S_SCAN;
            end else begin
              state_nxt = S_DONE;
            end
          end
          vptt_pkg::CMD_ALARM: begin
            ctl.alarm = 1'b1;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = sts.enabled ? S_DONE : S_START;
      end
      S_START: begin
        ctl.start = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (sts.scan_more) begin
          ctl.scan_step = 1'b1;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        ctl.diff  = 1'b1;
        state_nxt = S_REARM;
      end
      S_REARM: begin
        ctl.rearm = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          ctl.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `VPTT_ASSERT_NXT(a_accept_decode, clk, rst_n, in_valid && in_ready, state_r == S_DECODE)
  `VPTT_ASSERT_IMP(a_scan_entry, clk, rst_n, state_r == S_SCAN, $past(state_r) == S_DECODE || $past(state_r) == S_SCAN)
  `VPTT_ASSERT_NXT(a_publish_valid, clk, rst_n, ctl.publish, out_valid_r)

endmodule

>>> hdl/vptt_dp.sv
// Datapath of the tick timer: timer state, catch-up counter, result registers.
`include "virtual_periodic_tick_timer_unit_assert.svh"
module vptt_dp #(
  parameter int MAX_CATCHUP = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic [1:0]          in_command,
  input  logic [31:0]         in_period_us,
  input  logic [63:0]         in_vtime,
  input  logic [63:0]         in_tsc_now,
  input  vptt_pkg::vptt_ctl_t ctl,
  output vptt_pkg::vptt_sts_t sts,
  output logic [7:0]          out_expired_count,
  output logic                out_catchup_saturated,
  output logic                out_alarm_set,
  output logic [63:0]         out_alarm_time,
  output logic                out_alarm_cancel,
  output logic                out_tick_enabled
);

  localparam int CNT_W = $clog2(MAX_CATCHUP + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CATCHUP);

  // Timer state and configuration
  logic [15:0] tpu_r;
  logic        enabled_r;
  logic        pending_r;
  logic [63:0] deadline_r, deadline_nxt;
  logic [63:0] period_r;

  // Captured item
  logic [1:0]  cmd_r;
  logic [31:0] pusec_r;
  logic [63:0] vnow_r;
  logic [63:0] tsc_r;

  // Work and result registers
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      diff_r;
  logic [7:0]       res_count_r;
  logic             res_sat_r;
  logic             res_aset_r;
  logic [63:0]      res_atime_r;
  logic             res_cancel_r;

  logic [47:0] prod;
  logic [16:0] cnt_ext;
  logic [7:0]  cnt_clip;

  assign prod         = 48'(pusec_r) * 48'(tpu_r);
  assign deadline_nxt = deadline_r + period_r;
  assign cnt_ext      = 17'(cnt_r);
  assign cnt_clip     = (cnt_ext > 17'd255) ? 8'hFF : cnt_ext[7:0];

  assign sts.cmd       = cmd_r;
  assign sts.enabled   = enabled_r;
  assign sts.pending   = pending_r;
  assign sts.scan_more = (deadline_r <= vnow_r) && (cnt_r < CNT_MAX);

  // Update control state: config, mode, pending flag, deadline, period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r      <= vptt_pkg::TPU_RESET;
      enabled_r  <= 1'b0;
      pending_r  <= 1'b0;
      deadline_r <= '0;
      period_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        tpu_r <= cfg_wr_data;
      end
      if (ctl.mul) begin
        period_r <= 64'(prod);
      end
      if (ctl.start) begin
        deadline_r <= vnow_r + period_r;
        enabled_r  <= 1'b1;
      end
      if (ctl.disable_tmr) begin
        enabled_r <= 1'b0;
      end
      if (ctl.alarm) begin
        pending_r <= 1'b1;
      end
      if (ctl.poll_start) begin
        pending_r <= 1'b0;
      end
      if (ctl.scan_step) begin
        deadline_r <= deadline_nxt;
      end
    end
  end

  // Capture the item, run catch-up, build the result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r        <= in_command;
      pusec_r      <= in_period_us;
      vnow_r       <= in_vtime;
      tsc_r        <= in_tsc_now;
      res_count_r  <= '0;
      res_sat_r    <= 1'b0;
      res_aset_r   <= 1'b0;
      res_atime_r  <= '0;
      res_cancel_r <= 1'b0;
    end
    if (ctl.start) begin
      res_aset_r  <= 1'b1;
      res_atime_r <= tsc_r + period_r;
    end
    if (ctl.disable_tmr) begin
      res_cancel_r <= 1'b1;
    end
    if (ctl.poll_start) begin
      cnt_r <= '0;
    end
    if (ctl.scan_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (ctl.diff) begin
      diff_r <= deadline_r - vnow_r;
    end
    if (ctl.rearm) begin
      res_count_r <= cnt_clip;
      res_sat_r   <= (cnt_r == CNT_MAX);
      res_aset_r  <= 1'b1;
      res_atime_r <= tsc_r + diff_r;
    end
  end

  // Drive the output register
  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_expired_count     <= res_count_r;
      out_catchup_saturated <= res_sat_r;
      out_alarm_set         <= res_aset_r;
      out_alarm_time        <= res_atime_r;
      out_alarm_cancel      <= res_cancel_r;
      out_tick_enabled      <= enabled_r;
    end
  end

  `VPTT_ASSERT_NXT(a_scan_advance, clk, rst_n, ctl.scan_step, deadline_r == $past(deadline_r) + $past(period_r))
  `VPTT_ASSERT_NXT(a_start_arms, clk, rst_n, ctl.start, enabled_r && res_aset_r)
  `VPTT_ASSERT_NXT(a_poll_clears, clk, rst_n, ctl.poll_start, !pending_r)

endmodule

>>> hdl/virtual_periodic_tick_timer_unit.sv
// Top level of the virtual-time periodic tick timer.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  in       | in_valid / in_ready     | command, period_us, vtime, tsc_now
//  out      | out_valid / out_ready   | expired_count .. tick_enabled
//  cfg      | cfg_wr_en               | cfg_wr_data (ticks_per_usec)
//
// One item at a time. Disable, alarm and a poll with nothing pending go from
// decode to done; enable adds the multiply (and start if off); a pending poll
// scans up to MAX_CATCHUP deadlines, one add a cycle, then diff and rearm.
// A finished result sits in the output register; the next item is taken
// while it waits, and the block stalls before publishing until it is taken.
// Synchronous active-low reset; no clearing pass.
module virtual_periodic_tick_timer_unit #(
  parameter int MAX_CATCHUP = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_period_us,
  input  logic [63:0] in_vtime,
  input  logic [63:0] in_tsc_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_expired_count,
  output logic        out_catchup_saturated,
  output logic        out_alarm_set,
  output logic [63:0] out_alarm_time,
  output logic        out_alarm_cancel,
  output logic        out_tick_enabled
);

  vptt_pkg::vptt_ctl_t ctl;
  vptt_pkg::vptt_sts_t sts;

  // Sequence each item
  vptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Hold timer state and compute results
  vptt_dp #(
    .MAX_CATCHUP (MAX_CATCHUP)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_command            (in_command),
    .in_period_us          (in_period_us),
    .in_vtime              (in_vtime),
    .in_tsc_now            (in_tsc_now),
    .ctl                   (ctl),
    .sts                   (sts),
    .out_expired_count     (out_expired_count),
    .out_catchup_saturated (out_catchup_saturated),
    .out_alarm_set         (out_alarm_set),
    .out_alarm_time        (out_alarm_time),
    .out_alarm_cancel      (out_alarm_cancel),
    .out_tick_enabled      (out_tick_enabled)
  );

endmodule

>>> tb/tb_virtual_periodic_tick_timer_unit.sv
// Self-checking testbench for the virtual-time periodic tick timer.
module tb_virtual_periodic_tick_timer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CATCHUP_LIMIT = 255;
  // Longest item is a saturating poll, which scans CATCHUP_LIMIT deadlines
  localparam int SETTLE_CYCLES = CATCHUP_LIMIT + 16;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [7:0]  expired_count;
    logic        catchup_saturated;
    logic        alarm_set;
    logic [63:0] alarm_time;
    logic        alarm_cancel;
    logic        tick_enabled;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [31:0] in_period_us;
  logic [63:0] in_vtime;
  logic [63:0] in_tsc_now;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_expired_count;
  logic        out_catchup_saturated;
  logic        out_alarm_set;
  logic [63:0] out_alarm_time;
  logic        out_alarm_cancel;
  logic        out_tick_enabled;

  // Timer state as predicted from the accepted items
  logic [15:0] mdl_tpu;
  logic        mdl_enabled;
  logic        mdl_pending;
  logic [63:0] mdl_deadline;
  logic [63:0] mdl_period;

  tick_result_t due_results[$];
  int mismatches = 0;

  // Sender and receiver idling controls
  bit       tx_gaps = 1'b0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  logic [7:0] rx_pattern = 8'hff;
  bit       hold_request = 1'b0;

  virtual_periodic_tick_timer_unit #(
    .MAX_CATCHUP(CATCHUP_LIMIT)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_period_us          (in_period_us),
    .in_vtime              (in_vtime),
    .in_tsc_now            (in_tsc_now),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_expired_count     (out_expired_count),
    .out_catchup_saturated (out_catchup_saturated),
    .out_alarm_set         (out_alarm_set),
    .out_alarm_time        (out_alarm_time),
    .out_alarm_cancel      (out_alarm_cancel),
    .out_tick_enabled      (out_tick_enabled)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Apply one command to the predicted timer state and return its result
  function automatic tick_result_t advance_timer(logic [1:0] cmd, logic [31:0] pusec,
                                                 logic [63:0] vnow, logic [63:0] tnow);
    tick_result_t r;
    int n;
    r = '0;
    n = 0;
    case (cmd)
      vptt_pkg::CMD_ENABLE: begin
        mdl_period = {32'd0, pusec} * {48'd0, mdl_tpu};
        if (!mdl_enabled) begin
          mdl_deadline = vnow + mdl_period;
          r.alarm_set = 1'b1;
          r.alarm_time = tnow + mdl_period;
          mdl_enabled = 1'b1;
        end
      end
      vptt_pkg::CMD_DISABLE: begin
        if (mdl_enabled) begin
          r.alarm_cancel = 1'b1;
          mdl_enabled = 1'b0;
        end
      end
      vptt_pkg::CMD_ALARM: mdl_pending = 1'b1;
      default: begin
        if (mdl_pending) begin
          mdl_pending = 1'b0;
          // Count passed deadlines, bounded by the catch-up limit
          while (mdl_deadline <= vnow && n < CATCHUP_LIMIT) begin
            n++;
            mdl_deadline = mdl_deadline + mdl_period;
          end
          r.catchup_saturated = (n == CATCHUP_LIMIT);
          r.expired_count = (n > 255) ? 8'd255 : n[7:0];
          r.alarm_set = 1'b1;
          r.alarm_time = tnow + (mdl_deadline - vnow);
        end
      end
    endcase
    r.tick_enabled = mdl_enabled;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result with the oldest outstanding expectation
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("expired_count", want.expired_count, out_expired_count);
        check_field("catchup_saturated", want.catchup_saturated, out_catchup_saturated);
        check_field("alarm_set", want.alarm_set, out_alarm_set);
        check_field("alarm_time", want.alarm_time, out_alarm_time);
        check_field("alarm_cancel", want.alarm_cancel, out_alarm_cancel);
        check_field("tick_enabled", want.tick_enabled, out_tick_enabled);
      end
    end
  end

  // Receiver: drive ready per mode, or hold off for a long stretch on request
  initial begin
    int idx;
    idx = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready = 1'b1;
          RX_RANDOM: out_ready = ($urandom_range(0, 99) < 60);
          default:   out_ready = rx_pattern[idx % 8];
        endcase
        idx++;
      end
    end
  end

  // Offer one item, with a random gap between bursts, and predict it on acceptance
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] pusec,
                           input logic [63:0] vnow, input logic [63:0] tnow);
    int gap;
    gap = 0;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 10);
      end
      burst_left--;
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_period_us = pusec;
    in_vtime = vnow;
    in_tsc_now = tnow;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(advance_timer(cmd, pusec, vnow, tnow));
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ticks_per_usec(input logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    mdl_tpu = value;
  endtask

  function automatic logic [31:0] pick_period_us();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 2000);
    if (sel < 90) return $urandom();
    if (sel < 94) return 32'd0;
    if (sel < 97) return 32'd1;
    return 32'hffff_ffff;
  endfunction

  // Poll time placed around the predicted deadline
  function automatic logic [63:0] pick_poll_time();
    int sel;
    logic [63:0] offs;
    sel = $urandom_range(0, 99);
    offs = (mdl_period == 0) ? 64'd0 : rand64() % mdl_period;
    if (sel < 10) return mdl_deadline - $urandom_range(1, 1000);
    if (sel < 85) return mdl_deadline + $urandom_range(0, 10) * mdl_period + offs;
    if (sel < 95) return mdl_deadline + $urandom_range(200, 400) * mdl_period + offs;
    return rand64();
  endfunction

  // Mostly well-formed enable/alarm/poll/disable flow, some plain noise
  task automatic send_shaped_item();
    int sel;
    logic [1:0] cmd;
    logic [63:0] vn;
    sel = $urandom_range(0, 99);
    vn = rand64();
    if (sel < 12)
      cmd = 2'($urandom_range(0, 3));
    else if (!mdl_enabled)
      cmd = (sel < 85) ? vptt_pkg::CMD_ENABLE :
            ((sel < 92) ? vptt_pkg::CMD_ALARM : vptt_pkg::CMD_POLL);
    else if (mdl_pending)
      cmd = (sel < 85) ? vptt_pkg::CMD_POLL :
            ((sel < 92) ? vptt_pkg::CMD_ENABLE : vptt_pkg::CMD_DISABLE);
    else
      cmd = (sel < 65) ? vptt_pkg::CMD_ALARM : (sel < 75) ? vptt_pkg::CMD_DISABLE :
            (sel < 85) ? vptt_pkg::CMD_ENABLE : vptt_pkg::CMD_POLL;
    if (cmd == vptt_pkg::CMD_POLL && sel >= 12) vn = pick_poll_time();
    send_item(cmd, pick_period_us(), vn, rand64());
  endtask

  // Commands issued while the timer is off, including a serviced poll
  task automatic test_disabled_commands();
    send_item(vptt_pkg::CMD_POLL, 32'd0, 64'hffff_ffff_ffff_ffff, 64'd0);
    send_item(vptt_pkg::CMD_DISABLE, 32'hffff_ffff, 64'd0, 64'd0);
    send_item(vptt_pkg::CMD_ALARM, 32'd0, 64'd0, 64'd0);
    send_item(vptt_pkg::CMD_POLL, 32'd0, 64'd0, 64'hffff_ffff_ffff_ffff);
  endtask

  // Largest period with wrapping times, re-enable, polls around the deadline
  task automatic test_enable_extremes();
    send_item(vptt_pkg::CMD_ENABLE, 32'hffff_ffff, 64'hffff_ffff_ffff_fff0,
              64'hffff_ffff_ffff_ffff);
    send_item(vptt_pkg::CMD_ENABLE, 32'd1, 64'd0, 64'd0);
    send_item(vptt_pkg::CMD_ALARM, 32'd0, 64'd0, 64'd0);
    send_item(vptt_pkg::CMD_POLL, 32'd0, mdl_deadline - 64'd1, 64'h8000_0000_0000_0000);
    send_item(vptt_pkg::CMD_ALARM, 32'd0, 64'd0, 64'd0);
    send_item(vptt_pkg::CMD_POLL, 32'd0, mdl_deadline + 3 * mdl_period,
              64'h1234_5678_9abc_def0);
    send_item(vptt_pkg::CMD_DISABLE, 32'd0, 64'd0, 64'd0);
    send_item(vptt_pkg::CMD_DISABLE, 32'd0, 64'd0, 64'd0);
  endtask

  // Zero rate gives a zero period; the catch-up limit must bound the poll
  task automatic test_zero_rate();
    write_ticks_per_usec(16'd0);
    send_item(vptt_pkg::CMD_ENABLE, 32'd500, 64'd1000, 64'd0);
    send_item(vptt_pkg::CMD_ALARM, 32'd0, 64'd0, 64'd0);
    send_item(vptt_pkg::CMD_POLL, 32'd0, mdl_deadline, 64'd77);
    send_item(vptt_pkg::CMD_DISABLE, 32'd0, 64'd0, 64'd0);
  endtask

  // Deadline wraps past the top of the 64-bit time range
  task automatic test_deadline_wrap();
    write_ticks_per_usec(16'hffff);
    send_item(vptt_pkg::CMD_ENABLE, 32'hffff_ffff, 64'hffff_ffff_ffff_0000,
              64'hffff_ffff_0000_0000);
    send_item(vptt_pkg::CMD_ALARM, 32'd0, 64'd0, 64'd0);
    send_item(vptt_pkg::CMD_POLL, 32'd0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffe);
    send_item(vptt_pkg::CMD_DISABLE, 32'd0, 64'd0, 64'd0);
  endtask

  // Receiver holds off while the sender keeps offering, so the block stalls
  task automatic test_backpressure();
    write_ticks_per_usec(16'd1000);
    tx_gaps = 1'b0;
    rx_mode = RX_RANDOM;
    hold_request = 1'b1;
    repeat (40) send_shaped_item();
    drain_results();
  endtask

  // Random traffic over several rates and idling styles
  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_ticks_per_usec(16'd1); tx_gaps = 1'b0; rx_mode = RX_ALWAYS; end
        1: begin write_ticks_per_usec(16'hffff); tx_gaps = 1'b1; rx_mode = RX_RANDOM; end
        2: begin
          write_ticks_per_usec(16'($urandom_range(2, 65534)));
          tx_gaps = 1'b1;
          rx_mode = RX_PATTERN;
          rx_pattern = 8'($urandom()) | 8'h01;
        end
        3: begin
          write_ticks_per_usec(16'd0);
          tx_gaps = 1'b0;
          rx_mode = RX_PATTERN;
          rx_pattern = 8'($urandom()) | 8'h01;
        end
        default: begin write_ticks_per_usec(16'd1000); tx_gaps = 1'b1; rx_mode = RX_RANDOM; end
      endcase
      repeat (PHASE_ITEMS) send_shaped_item();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_command = vptt_pkg::CMD_ENABLE;
    in_period_us = '0;
    in_vtime = '0;
    in_tsc_now = '0;
    mdl_tpu = vptt_pkg::TPU_RESET;
    mdl_enabled = 1'b0;
    mdl_pending = 1'b0;
    mdl_deadline = '0;
    mdl_period = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_disabled_commands();
    test_enable_extremes();
    test_zero_rate();
    test_deadline_wrap();
    test_backpressure();
    test_random_traffic();
    drain_results();

    if (due_results.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
